/* hdl/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property at every rising edge while reset is released.
`define SFM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("similarity checker: property failed");
// Check a property at every rising edge, reset included.
`define SFM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("similarity checker: property failed during reset");
`endif

/* hdl/sfm_pkg.sv */
// Package with types, constants and tables of the two-point similarity estimator.
`default_nettype none
package sfm_pkg;

  localparam int unsigned ANGLE_ITERATIONS_DEF = 24;
  localparam int unsigned CORDIC_STAGES        = 32;
  localparam int unsigned CORDIC_W             = 36;
  localparam int unsigned ANGLE_W              = 34;
  localparam logic [31:0] PI_Q30               = 32'hC90F_DAA2;
  localparam logic [15:0] MAX_SCALE_RST        = 16'd1024;
  localparam logic [31:0] MAX_SCALE_SQ_RST     = 32'd1048576;

  typedef enum logic [1:0] {
    CFG_MAX_SCALE = 2'd0,
    CFG_ROT_ON    = 2'd1,
    CFG_MAX_ROT   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] first_src_x;
    logic signed [31:0] first_src_y;
    logic signed [31:0] first_dst_x;
    logic signed [31:0] first_dst_y;
    logic signed [31:0] second_src_x;
    logic signed [31:0] second_src_y;
    logic signed [31:0] second_dst_x;
    logic signed [31:0] second_dst_y;
  } in_item_t;

  typedef struct packed {
    logic               model_valid;
    logic signed [31:0] coef_xx;
    logic signed [31:0] coef_xy;
    logic signed [31:0] offset_x;
    logic signed [31:0] coef_yx;
    logic signed [31:0] coef_yy;
    logic signed [31:0] offset_y;
  } out_item_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000007;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* hdl/similarity_from_two_matches.sv */
// Top level of the two-point similarity estimator: pipeline, config registers, output stage.
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_item_i) takes one hypothesis of two point
//   matches per transfer; output channel (out_valid_o / out_ready_i / out_item_o) gives
//   one 2x3 similarity model per hypothesis, in order.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i) is always ready;
//   index 0 max_scale, 1 rotation_check_on, 2 max_rotation, other indexes are dropped.
//   Write config only while no hypothesis is in flight.
// Timing:
//   Throughput is one hypothesis per cycle while no stall holds the pipeline. An input
//   transfer reaches out_valid_o through 41 pipeline stages and then the output register;
//   the stage count is set by the 32-step restoring dividers for the coefficients, and the
//   32-stage angle CORDIC runs beside them. The stage count does not depend on
//   ANGLE_ITERATIONS; stages past the last micro-rotation only pass data along.
// Reset:
//   Clears all valid bits and loads the config reset values (max_scale 1024, rotation
//   check off, max_rotation 0). No result is shown during reset.
// Stall:
//   A result waiting in the output register does not block the pipeline while its last
//   stage is empty; once that stage also holds a result, the whole pipeline holds and
//   in_ready_o drops until out_ready_i takes the waiting result.
`default_nettype none
module similarity_from_two_matches #(
  parameter int unsigned ANGLE_ITERATIONS = sfm_pkg::ANGLE_ITERATIONS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire sfm_pkg::in_item_t   in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output sfm_pkg::out_item_t       out_item_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [15:0]         cfg_data_i
);

  // Stage numbers of the main pipeline.
  localparam int unsigned ST_SCALE = 5;
  localparam int unsigned ST_ROT   = 35;
  localparam int unsigned ST_LAST  = 41;

  typedef struct packed {
    logic signed [31:0] a1x;
    logic signed [31:0] a1y;
    logic signed [31:0] b1x;
    logic signed [31:0] b1y;
  } pts_t;

  typedef struct packed {
    logic zero;
    logic neg_dot;
    logic neg_crs;
    logic too_big;
    logic too_small;
    logic rot_bad;
  } flags_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] max_scale_q;
  logic        rot_on_q;
  logic [15:0] max_rot_q;
  logic [31:0] m2_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_scale_q <= sfm_pkg::MAX_SCALE_RST;
      rot_on_q    <= 1'b0;
      max_rot_q   <= '0;
    end else if (cfg_valid_i) begin
      case (sfm_pkg::cfg_idx_e'(cfg_index_i))
        sfm_pkg::CFG_MAX_SCALE: max_scale_q <= cfg_data_i;
        sfm_pkg::CFG_ROT_ON:    rot_on_q    <= cfg_data_i[0];
        sfm_pkg::CFG_MAX_ROT:   max_rot_q   <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Square of max_scale, registered in the cycle after a write, long before stage 4 needs it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_q <= sfm_pkg::MAX_SCALE_SQ_RST;
    end else begin
      m2_q <= max_scale_q * max_scale_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: one enable for the whole pipeline
  // ---------------------------------------------------------------------------
  logic [ST_LAST:1] v_q;
  logic             out_v_q;
  logic             adv;

  assign adv        = !v_q[ST_LAST] || !out_v_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[ST_LAST-1:1], in_valid_i};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: register the points, form the differences
  // ---------------------------------------------------------------------------
  pts_t               pt_q [1:ST_LAST-1];
  logic signed [32:0] adx_q, ady_q, bdx_q, bdy_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pt_q[1].a1x <= in_item_i.first_src_x;
      pt_q[1].a1y <= in_item_i.first_src_y;
      pt_q[1].b1x <= in_item_i.first_dst_x;
      pt_q[1].b1y <= in_item_i.first_dst_y;
      adx_q <= 33'(in_item_i.second_src_x) - 33'(in_item_i.first_src_x);
      ady_q <= 33'(in_item_i.second_src_y) - 33'(in_item_i.first_src_y);
      bdx_q <= 33'(in_item_i.second_dst_x) - 33'(in_item_i.first_dst_x);
      bdy_q <= 33'(in_item_i.second_dst_y) - 33'(in_item_i.first_dst_y);
    end
  end

  // Carry the first points down to the offset stages.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 2; s < ST_LAST; s++) begin
        pt_q[s] <= pt_q[s-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: products of the differences
  // ---------------------------------------------------------------------------
  logic signed [65:0] p_axx_q, p_ayy_q, p_bxx_q, p_byy_q;
  logic signed [65:0] p_dx_q, p_dy_q, p_cxy_q, p_cyx_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_axx_q <= adx_q * adx_q;
      p_ayy_q <= ady_q * ady_q;
      p_bxx_q <= bdx_q * bdx_q;
      p_byy_q <= bdy_q * bdy_q;
      p_dx_q  <= adx_q * bdx_q;
      p_dy_q  <= ady_q * bdy_q;
      p_cxy_q <= adx_q * bdy_q;
      p_cyx_q <= ady_q * bdx_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: squared lengths, dot and cross products
  // ---------------------------------------------------------------------------
  logic [65:0]        a_q, b_q;
  logic signed [66:0] dot_q, crs_q;
  logic [65:0]        a_d;
  logic signed [66:0] dot_d, crs_d;
  flags_t             fl_q [3:ST_LAST-1];

  assign a_d   = 66'(p_axx_q) + 66'(p_ayy_q);
  assign dot_d = 67'(p_dx_q) + 67'(p_dy_q);
  assign crs_d = 67'(p_cxy_q) - 67'(p_cyx_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q   <= a_d;
      b_q   <= 66'(p_bxx_q) + 66'(p_byy_q);
      dot_q <= dot_d;
      crs_q <= crs_d;
      fl_q[3] <= '{zero: (a_d == '0), neg_dot: dot_d[66], neg_crs: crs_d[66],
                   too_big: 1'b0, too_small: 1'b0, rot_bad: 1'b0};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: scale bound partial products, magnitudes for the dividers
  // ---------------------------------------------------------------------------
  logic [63:0]        am_lo_q, bm_lo_q;
  logic [65:0]        am_hi_q, bm_hi_q;
  logic [65:0]        a4_q, b4_q;
  logic [65:0]        mag_dot_q, mag_crs_q;
  logic signed [66:0] dot_abs, crs_abs;

  assign dot_abs = dot_q[66] ? -dot_q : dot_q;
  assign crs_abs = crs_q[66] ? -crs_q : crs_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      am_lo_q   <= a_q[31:0] * m2_q;
      am_hi_q   <= a_q[65:32] * m2_q;
      bm_lo_q   <= b_q[31:0] * m2_q;
      bm_hi_q   <= b_q[65:32] * m2_q;
      a4_q      <= a_q;
      b4_q      <= b_q;
      mag_dot_q <= dot_abs[65:0];
      mag_crs_q <= crs_abs[65:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: scale checks (equality passes)
  // ---------------------------------------------------------------------------
  logic [97:0] am, bm;
  logic        too_big, too_small;

  assign am        = {am_hi_q, 32'b0} + {34'b0, am_lo_q};
  assign bm        = {bm_hi_q, 32'b0} + {34'b0, bm_lo_q};
  assign too_big   = {16'b0, b4_q, 16'b0} > am;
  assign too_small = bm < {16'b0, a4_q, 16'b0};

  // ---------------------------------------------------------------------------
  // Stages 2..35: angle difference for the rotation limit
  // ---------------------------------------------------------------------------
  logic signed [sfm_pkg::ANGLE_W-1:0] za, zb;
  logic signed [sfm_pkg::ANGLE_W:0]   rot, rot_abs;
  logic                               rot_bad;

  sfm_cordic #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_cordic_a (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (adx_q),
    .y_i   (ady_q),
    .z_o   (za)
  );

  sfm_cordic #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_cordic_b (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (bdx_q),
    .y_i   (bdy_q),
    .z_o   (zb)
  );

  assign rot     = (sfm_pkg::ANGLE_W + 1)'(zb) - (sfm_pkg::ANGLE_W + 1)'(za);
  assign rot_abs = rot[sfm_pkg::ANGLE_W] ? -rot : rot;
  assign rot_bad = rot_abs[sfm_pkg::ANGLE_W-1:0] > {1'b0, max_rot_q, 17'b0};

  // Carry the flags; fill in each check at the stage that computes it.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 4; s < ST_LAST; s++) begin
        fl_q[s] <= fl_q[s-1];
        if (s == ST_SCALE) begin
          fl_q[s].too_big   <= too_big;
          fl_q[s].too_small <= too_small;
        end
        if (s == ST_ROT) begin
          fl_q[s].rot_bad <= rot_bad;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 5..38: coefficient quotients
  // ---------------------------------------------------------------------------
  logic [31:0] q_dot, q_crs;
  logic        ovf_dot, ovf_crs;

  sfm_divider u_div_dot (
    .clk_i (clk_i),
    .en_i  (adv),
    .mag_i (mag_dot_q),
    .den_i (a4_q),
    .q_o   (q_dot),
    .ovf_o (ovf_dot)
  );

  sfm_divider u_div_crs (
    .clk_i (clk_i),
    .en_i  (adv),
    .mag_i (mag_crs_q),
    .den_i (a4_q),
    .q_o   (q_crs),
    .ovf_o (ovf_crs)
  );

  function automatic logic signed [31:0] sat_pos(input logic [31:0] q, input logic ovf);
    return (ovf || q[31]) ? 32'sh7FFF_FFFF : $signed(q);
  endfunction

  function automatic logic signed [31:0] sat_neg(input logic [31:0] q, input logic ovf);
    return (ovf || (q[31] && (q[30:0] != '0))) ? 32'sh8000_0000 : -$signed(q);
  endfunction

  // ---------------------------------------------------------------------------
  // Stage 39: signed, saturated coefficients; zero when the sources coincide
  // ---------------------------------------------------------------------------
  logic signed [31:0] cxx39_q, cxy39_q, cyx39_q;
  logic signed [31:0] cxx40_q, cxy40_q, cyx40_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (fl_q[38].zero) begin
        cxx39_q <= '0;
        cxy39_q <= '0;
        cyx39_q <= '0;
      end else begin
        cxx39_q <= fl_q[38].neg_dot ? sat_neg(q_dot, ovf_dot) : sat_pos(q_dot, ovf_dot);
        cyx39_q <= fl_q[38].neg_crs ? sat_neg(q_crs, ovf_crs) : sat_pos(q_crs, ovf_crs);
        cxy39_q <= fl_q[38].neg_crs ? sat_pos(q_crs, ovf_crs) : sat_neg(q_crs, ovf_crs);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 40: products for the translation
  // ---------------------------------------------------------------------------
  logic signed [63:0] m0x_q, m1x_q, m0y_q, m1y_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m0x_q   <= cxx39_q * pt_q[39].a1x;
      m1x_q   <= cxy39_q * pt_q[39].a1y;
      m0y_q   <= cyx39_q * pt_q[39].a1x;
      m1y_q   <= cxx39_q * pt_q[39].a1y;
      cxx40_q <= cxx39_q;
      cxy40_q <= cxy39_q;
      cyx40_q <= cyx39_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 41: offsets, round half up, saturate; assemble the result
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] offset_of(input logic signed [31:0] dst,
                                                   input logic signed [63:0] m0,
                                                   input logic signed [63:0] m1);
    logic signed [64:0] sum;
    logic signed [64:0] h;
    logic signed [65:0] d;
    sum = 65'(m0) + 65'(m1) + 65'sd32768;
    h   = sum >>> 16;
    d   = 66'(dst) - 66'(h);
    if (d > 66'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (d < -66'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return d[31:0];
  endfunction

  sfm_pkg::out_item_t res_q, out_q;
  flags_t             fl_end;

  assign fl_end = fl_q[ST_LAST-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q.model_valid <= !fl_end.zero && !fl_end.too_big && !fl_end.too_small &&
                           !(rot_on_q && fl_end.rot_bad);
      res_q.coef_xx  <= cxx40_q;
      res_q.coef_xy  <= cxy40_q;
      res_q.coef_yx  <= cyx40_q;
      res_q.coef_yy  <= cxx40_q;
      res_q.offset_x <= fl_end.zero ? 32'sd0 : offset_of(pt_q[40].b1x, m0x_q, m1x_q);
      res_q.offset_y <= fl_end.zero ? 32'sd0 : offset_of(pt_q[40].b1y, m0y_q, m1y_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: load from the last stage, drop on transfer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv && v_q[ST_LAST]) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v_q[ST_LAST]) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

/* hdl/sfm_cordic.sv */
// Pipelined vectoring CORDIC that returns the angle of a vector in Q4.30.
`default_nettype none
module sfm_cordic #(
  parameter int unsigned ANGLE_ITERATIONS = sfm_pkg::ANGLE_ITERATIONS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic signed [32:0]                  x_i,
  input  wire logic signed [32:0]                  y_i,
  output logic signed [sfm_pkg::ANGLE_W-1:0]       z_o
);

  localparam int unsigned XW = sfm_pkg::CORDIC_W;
  localparam int unsigned ZW = sfm_pkg::ANGLE_W;
  localparam int unsigned NS = sfm_pkg::CORDIC_STAGES;
  localparam logic signed [ZW-1:0] PI_Z = ZW'(sfm_pkg::PI_Q30);

  logic signed [XW-1:0] x_q [0:NS];
  logic signed [XW-1:0] y_q [0:NS];
  logic signed [ZW-1:0] z_q [0:NS];

  // Fold the left half plane onto the right one.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (x_i[32]) begin
        x_q[0] <= -XW'(x_i);
        y_q[0] <= -XW'(y_i);
        z_q[0] <= y_i[32] ? -PI_Z : PI_Z;
      end else begin
        x_q[0] <= XW'(x_i);
        y_q[0] <= XW'(y_i);
        z_q[0] <= '0;
      end
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_stage
    localparam int unsigned I = k - 1;
    if (I < ANGLE_ITERATIONS) begin : g_rot
      logic signed [ZW-1:0] step;
      assign step = ZW'(sfm_pkg::atan_q30(5'(I)));
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (!y_q[k-1][XW-1]) begin
            x_q[k] <= x_q[k-1] + (y_q[k-1] >>> I);
            y_q[k] <= y_q[k-1] - (x_q[k-1] >>> I);
            z_q[k] <= z_q[k-1] + step;
          end else begin
            x_q[k] <= x_q[k-1] - (y_q[k-1] >>> I);
            y_q[k] <= y_q[k-1] + (x_q[k-1] >>> I);
            z_q[k] <= z_q[k-1] - step;
          end
        end
      end
    end else begin : g_pass
      // Hold the latency fixed past the last micro-rotation.
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[k] <= x_q[k-1];
          y_q[k] <= y_q[k-1];
          z_q[k] <= z_q[k-1];
        end
      end
    end
  end

  assign z_o = z_q[NS];

endmodule
`default_nettype wire

/* hdl/sfm_divider.sv */
// Pipelined restoring divider: floor((mag*2^17 + den) / (2*den)), 32 quotient bits.
`default_nettype none
module sfm_divider (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [65:0] mag_i,
  input  wire logic [65:0] den_i,
  output logic [31:0]      q_o,
  output logic             ovf_o
);

  localparam int unsigned NW = 84;
  localparam int unsigned DW = 67;
  localparam int unsigned CW = 99;
  localparam int unsigned QB = 32;

  logic [NW-1:0] n_q;
  logic [DW-1:0] d0_q;
  logic [NW-1:0] r_q   [0:QB];
  logic [DW-1:0] d_q   [0:QB];
  logic [QB-1:0] q_q   [0:QB];
  logic          ovf_q [0:QB];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q  <= {1'b0, mag_i, 17'b0} + {18'b0, den_i};
      d0_q <= {den_i, 1'b0};
    end
  end

  // Flag quotients of 2^32 and above, then start the bit steps.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= {15'b0, n_q} >= {d0_q, 32'b0};
      r_q[0]   <= n_q;
      d_q[0]   <= d0_q;
      q_q[0]   <= '0;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int unsigned K = QB - 1 - j;
    logic [CW-1:0] dk;
    logic          ge;
    assign dk = {32'b0, d_q[j]} << K;
    assign ge = {15'b0, r_q[j]} >= dk;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j+1]   <= ge ? (r_q[j] - dk[NW-1:0]) : r_q[j];
        d_q[j+1]   <= d_q[j];
        q_q[j+1]   <= {q_q[j][QB-2:0], ge};
        ovf_q[j+1] <= ovf_q[j];
      end
    end
  end

  assign q_o   = q_q[QB];
  assign ovf_o = ovf_q[QB];

endmodule
`default_nettype wire

/* hdl/sfm_checker.sv */
// Port-level checker for the similarity estimator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module sfm_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire sfm_pkg::in_item_t  in_item_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire sfm_pkg::out_item_t out_item_o,
  input wire logic               cfg_valid_i,
  input wire logic               cfg_ready_o,
  input wire logic [1:0]         cfg_index_i,
  input wire logic [15:0]        cfg_data_i
);

  logic stalled;
  assign stalled = out_valid_o && !out_ready_i;

  `SFM_ASSERT(a_out_hold, clk_i, rst_ni, stalled |=> out_valid_o)
  `SFM_ASSERT(a_out_stable, clk_i, rst_ni, stalled |=> $stable(out_item_o))
  `SFM_ASSERT(a_diag_equal, clk_i, rst_ni, out_valid_o |-> (out_item_o.coef_xx == out_item_o.coef_yy))
  `SFM_ASSERT(a_valid_nonzero, clk_i, rst_ni, (out_valid_o && out_item_o.model_valid) |-> (out_item_o.coef_xx != 0 || out_item_o.coef_yx != 0))
  `SFM_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_valid_o)

endmodule

bind similarity_from_two_matches sfm_checker u_sfm_checker (.*);
`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the two-point similarity estimator.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import sfm_pkg::*;

  localparam int unsigned ITERS     = 24;
  localparam int unsigned LATENCY   = 42;
  localparam logic [1:0]  CFG_SPARE = 2'd3;  // unmapped index, write must be dropped

  typedef logic signed [135:0] wide_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;

  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold_cycles;

  always #10 clk_i = ~clk_i;

  similarity_from_two_matches #(.ANGLE_ITERATIONS(ITERS)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_item_o(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // Predicts each model and holds the ones not yet seen at the output.
  class model_scoreboard;
    out_item_t pending_models[$];
    int mismatches;
    logic [15:0] max_scale;
    logic rot_check_on;
    logic [15:0] max_rot;
    longint atan_steps[32];

    function new();
      atan_steps = '{
        'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
        'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
        'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
        'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
        'h0000003F, 'h0000001F, 'h0000000F, 'h00000007, 'h00000003, 'h00000001,
        0, 0};
      max_scale = MAX_SCALE_RST;
      rot_check_on = 1'b0;
      max_rot = 16'd0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_MAX_SCALE: max_scale = data;
        CFG_ROT_ON:    rot_check_on = data[0];
        CFG_MAX_ROT:   max_rot = data;
        default: ;
      endcase
    endfunction

    // Vectoring CORDIC angle in Q4.30; fold negative x with a +-pi start.
    function longint vector_angle(longint x, longint y);
      longint z, xs, ys;
      z = 0;
      if (x < 0) begin
        z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
        x = -x;
        y = -y;
      end
      for (int i = 0; i < ITERS && i < 32; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += atan_steps[i];
        end else begin
          x -= ys; y += xs; z -= atan_steps[i];
        end
      end
      return z;
    endfunction

    // round(num * 2^16 / den), ties away from zero, saturated to 32 bits
    function logic signed [31:0] scaled_ratio(wide_t num, wide_t den);
      wide_t mag, q;
      mag = (num < 0) ? -num : num;
      q = ((mag <<< 17) + den) / (den <<< 1);
      if (num < 0) return (q > 136'sd2147483648) ? 32'sh80000000 : 32'(-q);
      return (q > 136'sd2147483647) ? 32'sh7FFFFFFF : 32'(q);
    endfunction

    function logic signed [31:0] offset_term(logic signed [31:0] dst,
        logic signed [31:0] c0, logic signed [31:0] p0,
        logic signed [31:0] c1, logic signed [31:0] p1);
      longint m0, m1, frac, h, r;
      m0 = longint'(c0) * longint'(p0);
      m1 = longint'(c1) * longint'(p1);
      frac = (m0 & 'hFFFF) + (m1 & 'hFFFF) + 'h8000;
      h = (m0 >>> 16) + (m1 >>> 16) + (frac >>> 16);
      r = longint'(dst) - h;
      if (r > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (r < -64'sd2147483648) return 32'sh80000000;
      return 32'(r);
    endfunction

    function void note_input(in_item_t it);
      longint adx, ady, bdx, bdy, rot, m2;
      wide_t sq_a, sq_b, dot, crs;
      out_item_t m;
      adx = longint'(it.second_src_x) - longint'(it.first_src_x);
      ady = longint'(it.second_src_y) - longint'(it.first_src_y);
      bdx = longint'(it.second_dst_x) - longint'(it.first_dst_x);
      bdy = longint'(it.second_dst_y) - longint'(it.first_dst_y);
      sq_a = wide_t'(adx) * wide_t'(adx) + wide_t'(ady) * wide_t'(ady);
      sq_b = wide_t'(bdx) * wide_t'(bdx) + wide_t'(bdy) * wide_t'(bdy);
      m2 = longint'(max_scale) * longint'(max_scale);
      m = '0;
      m.model_valid = (sq_a != 0);
      // scale bounds, equality passes
      if ((sq_b <<< 16) > sq_a * wide_t'(m2)) m.model_valid = 1'b0;
      if (sq_b * wide_t'(m2) < (sq_a <<< 16)) m.model_valid = 1'b0;
      if (rot_check_on) begin
        rot = vector_angle(bdx, bdy) - vector_angle(adx, ady);
        if (rot < 0) rot = -rot;
        if (rot > (longint'(max_rot) <<< 17)) m.model_valid = 1'b0;
      end
      if (sq_a != 0) begin
        dot = wide_t'(adx) * wide_t'(bdx) + wide_t'(ady) * wide_t'(bdy);
        crs = wide_t'(adx) * wide_t'(bdy) - wide_t'(ady) * wide_t'(bdx);
        m.coef_xx = scaled_ratio(dot, sq_a);
        m.coef_yy = m.coef_xx;
        m.coef_yx = scaled_ratio(crs, sq_a);
        m.coef_xy = scaled_ratio(-crs, sq_a);
        m.offset_x = offset_term(it.first_dst_x, m.coef_xx, it.first_src_x,
                                 m.coef_xy, it.first_src_y);
        m.offset_y = offset_term(it.first_dst_y, m.coef_yx, it.first_src_x,
                                 m.coef_xx, it.first_src_y);
      end
      pending_models.push_back(m);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending_models.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected model %h", got);
        return;
      end
      e = pending_models.pop_front();
      if (got.model_valid !== e.model_valid || got.coef_xx !== e.coef_xx ||
          got.coef_xy !== e.coef_xy || got.offset_x !== e.offset_x ||
          got.coef_yx !== e.coef_yx || got.coef_yy !== e.coef_yy ||
          got.offset_y !== e.offset_y) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("model mismatch: valid exp %0d got %0d", e.model_valid, got.model_valid);
          $display("  xx %h/%h xy %h/%h ox %h/%h", e.coef_xx, got.coef_xx,
                   e.coef_xy, got.coef_xy, e.offset_x, got.offset_x);
          $display("  yx %h/%h yy %h/%h oy %h/%h", e.coef_yx, got.coef_yx,
                   e.coef_yy, got.coef_yy, e.offset_y, got.offset_y);
        end
      end
    endfunction
  endclass

  model_scoreboard sb = new();

  // Observe transfers on both channels with pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready) sb.note_input(in_item);
    if (rst_ni && out_valid && out_ready) sb.check_result(out_item);
  end

  // Receiver: random stalls, or a long hold-off when requested.
  always @(posedge clk_i) begin
    if (recv_hold_cycles > 0) begin
      out_ready <= 1'b0;
      recv_hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offer one hypothesis, idling at random first; return after its transfer.
  task automatic send_hypothesis(in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic drain_models();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_models.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(logic [15:0] scale, logic rot_on, logic [15:0] rot);
    write_reg(CFG_MAX_SCALE, scale);
    write_reg(CFG_ROT_ON, {15'd0, rot_on});
    write_reg(CFG_MAX_ROT, rot);
  endtask

  function automatic in_item_t make_pair(logic signed [31:0] a1x, logic signed [31:0] a1y,
      logic signed [31:0] b1x, logic signed [31:0] b1y, logic signed [31:0] a2x,
      logic signed [31:0] a2y, logic signed [31:0] b2x, logic signed [31:0] b2y);
    return '{a1x, a1y, b1x, b1y, a2x, a2y, b2x, b2y};
  endfunction

  function automatic logic signed [31:0] small_coord(int unsigned bits);
    return $signed($urandom) >>> (32 - bits);
  endfunction

  // Mostly well-formed matches of modest size, with full-range noise mixed in.
  function automatic in_item_t random_hypothesis();
    in_item_t it;
    int unsigned bits;
    logic signed [31:0] dx, dy;
    bits = $urandom_range(4, 26);
    it = make_pair(small_coord(bits), small_coord(bits), small_coord(bits),
                   small_coord(bits), 0, 0, 0, 0);
    dx = small_coord(bits);
    dy = small_coord(bits);
    it.second_src_x = it.first_src_x + dx;
    it.second_src_y = it.first_src_y + dy;
    case ($urandom_range(0, 9))
      0, 1: it = make_pair($urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom);
      2: begin  // coincident sources
        it.second_src_x = it.first_src_x;
        it.second_src_y = it.first_src_y;
        it.second_dst_x = small_coord(bits);
        it.second_dst_y = small_coord(bits);
      end
      3: begin  // scale of exactly four, a boundary at the reset limit
        it.second_dst_x = it.first_dst_x + (dx <<< 2);
        it.second_dst_y = it.first_dst_y + (dy <<< 2);
      end
      4: begin  // quarter turn
        it.second_dst_x = it.first_dst_x - dy;
        it.second_dst_y = it.first_dst_y + dx;
      end
      5: begin  // half turn, angles near +-pi
        it.second_dst_x = it.first_dst_x - dx;
        it.second_dst_y = it.first_dst_y - dy;
      end
      default: begin
        it.second_dst_x = it.first_dst_x + small_coord(bits);
        it.second_dst_y = it.first_dst_y + small_coord(bits);
      end
    endcase
    return it;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_hypothesis(random_hypothesis());
  endtask

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold_cycles = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed hypotheses at reset settings
    send_hypothesis('0);
    send_hypothesis({8{32'h7FFFFFFF}});
    send_hypothesis({8{32'h80000000}});
    send_hypothesis({8{32'hFFFFFFFF}});
    send_hypothesis({8{32'h55555555}});
    send_hypothesis({8{32'hAAAAAAAA}});
    send_hypothesis(make_pair(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                              32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000));
    send_hypothesis(make_pair(32'h80000000, 0, 0, 0, 32'h7FFFFFFF, 0, 1, 0));
    send_hypothesis(make_pair(0, 0, 0, 0, 65536, 0, 262144, 0));
    send_hypothesis(make_pair(0, 0, 0, 0, 262144, 0, 65536, 0));
    send_hypothesis(make_pair(0, 0, 0, 0, 262145, 0, 65536, 0));
    send_hypothesis(make_pair(0, 0, 0, 0, 65536, 0, -65536, 0));
    send_hypothesis(make_pair(0, 0, 0, 0, -65536, 0, 65536, 0));
    send_hypothesis(make_pair(0, 0, 0, 0, -65536, -1, -65536, 1));
    send_hypothesis(make_pair(100, 200, 300, 400, 100, 200, 5000, 6000));
    send_hypothesis(make_pair(32'h7FFFFFFF, 32'h80000000, 32'h12345678, 32'h9ABCDEF0,
                              32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
    send_hypothesis(make_pair(3, -7, 11, 13, 3, -6, 11, 14));
    drain_models();

    // widest limits, rotation check open fully; spare index must be ignored
    set_regs(16'hFFFF, 1'b1, 16'hFFFF);
    write_reg(CFG_SPARE, 16'h0000);
    send_hypothesis(make_pair(0, 0, 0, 0, -65536, 0, 65536, 1));
    send_hypothesis(make_pair(0, 0, 0, 0, 65536, 0, 0, 65536));
    send_idle_pct = 14;
    recv_idle_pct = 59;
    run_random(300);
    drain_models();

    // zero limits: every model invalid
    set_regs(16'd0, 1'b1, 16'd0);
    run_random(100);
    drain_models();

    // tightest allowed scale, random rotation limit, roles of idling swapped
    set_regs(16'd256, 1'b1, 16'($urandom_range(0, 30000)));
    send_idle_pct = 59;
    recv_idle_pct = 14;
    run_random(150);
    recv_hold_cycles = 300;  // fill the pipeline and stall its input
    send_idle_pct = 0;
    run_random(150);
    drain_models();  // sender pauses until every model has come out

    // random settings, no idling
    set_regs(16'($urandom_range(256, 65535)), 1'b0, 16'($urandom));
    recv_idle_pct = 0;
    run_random(300);
    drain_models();
    set_regs(16'($urandom), 1'b1, 16'($urandom_range(0, 25736)));
    run_random(300);
    drain_models();

    repeat (LATENCY + 10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_models.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #(20 * 600000);
    $display("testbench: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
